FILE: rtl/zbtr_pkg.sv
package zbtr_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;

  // Integer bits carried above the fraction in edge and span accumulators.
  localparam int INT_W = 16;
  // Divisor width: vertical extents reach 4095, spans stay below 1024.
  localparam int DEN_W = 14;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0] DEPTH_FAR = 8'h80;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [7:0]  z;
  } vtx_t;

  typedef struct packed {
    logic       func;
    vtx_t       top;
    vtx_t       mid;
    vtx_t       bot;
    logic [7:0] colour;
  } cmd_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_colour;
    logic        triangle_done;
  } res_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LINE,
    PH_SPAN
  } phase_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_WAIT,
    S_LD_DIV,
    S_LD_WAIT,
    S_LD_FIN,
    S_LN_DIV,
    S_LN_WAIT,
    S_LN_STEP,
    S_LN_EVAL,
    S_SP_WAIT,
    S_PX_RD,
    S_PX_WR
  } state_t;

endpackage

FILE: rtl/zbuffer_triangle_rasterizer_core.sv
// Z-buffered scanline triangle rasterizer. A load transaction (func 0) takes three
// vertices and a colour, sorts them by y and sets up fixed-point edge slopes; it
// returns nothing. Each tick transaction (func 1) returns exactly one result: one
// candidate pixel of the current span, one empty or clipped scanline, or an idle
// result with triangle_done set. After reset the depth store is swept to the far
// value before the first transaction is processed; inputs are still queued
// meanwhile. A load runs four slope divisions on the shared radix-2 divider.
// A pixel inside a span goes through command, depth read, and compare and
// write on the depth memory. The tick that enters a non-empty scanline
// waits for one span-slope division, and the line just past the middle vertex
// adds the x and z edge-slope divisions. A tick also waits while the previous result
// has not been popped. A two-entry input queue and a one-entry result slot let
// either side stall independently. The depth_test_enable register (reset 1) may
// only be written while no transaction is in flight.
module zbuffer_triangle_rasterizer_core #(
  parameter int FRAC_BITS     = zbtr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH  = zbtr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = zbtr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic signed [11:0] in_a_x,
  input  logic signed [11:0] in_a_y,
  input  logic signed [7:0]  in_a_z,
  input  logic signed [11:0] in_b_x,
  input  logic signed [11:0] in_b_y,
  input  logic signed [7:0]  in_b_z,
  input  logic signed [11:0] in_c_x,
  input  logic signed [11:0] in_c_y,
  input  logic signed [7:0]  in_c_z,
  input  logic [7:0]         in_colour,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_write_valid,
  output logic [15:0]        out_pixel_address,
  output logic [7:0]         out_pixel_colour,
  output logic               out_triangle_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_depth_test_enable
);

  logic           dte_r, dte_nxt;
  logic           cmd_valid, cmd_pop, res_valid;
  zbtr_pkg::cmd_t cmd;
  zbtr_pkg::res_t res;

  // The configuration channel is always ready; the register is sampled on
  // every candidate pixel by the pixel stage.
  assign cfg_ready = 1'b1;
  assign dte_nxt   = (cfg_valid && cfg_ready) ? cfg_depth_test_enable : dte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dte_r <= 1'b1;
    end else begin
      dte_r <= dte_nxt;
    end
  end

  zbtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_a_x    (in_a_x),
    .in_a_y    (in_a_y),
    .in_a_z    (in_a_z),
    .in_b_x    (in_b_x),
    .in_b_y    (in_b_y),
    .in_b_z    (in_b_z),
    .in_c_x    (in_c_x),
    .in_c_y    (in_c_y),
    .in_c_z    (in_c_z),
    .in_colour (in_colour),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  zbtr_back #(
    .FRAC_BITS     (FRAC_BITS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .depth_test_enable (dte_r),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .res_valid         (res_valid),
    .res               (res),
    .res_pop           (out_pop)
  );

  // Results are presented straight from the back end's output register.
  assign out_empty         = !res_valid;
  assign out_write_valid   = res.write_valid;
  assign out_pixel_address = res.pixel_address;
  assign out_pixel_colour  = res.pixel_colour;
  assign out_triangle_done = res.triangle_done;

endmodule

FILE: rtl/zbtr_front.sv
module zbtr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_func,
  input  logic signed [11:0]   in_a_x,
  input  logic signed [11:0]   in_a_y,
  input  logic signed [7:0]    in_a_z,
  input  logic signed [11:0]   in_b_x,
  input  logic signed [11:0]   in_b_y,
  input  logic signed [7:0]    in_b_z,
  input  logic signed [11:0]   in_c_x,
  input  logic signed [11:0]   in_c_y,
  input  logic signed [7:0]    in_c_z,
  input  logic [7:0]           in_colour,
  output logic                 cmd_valid,
  output zbtr_pkg::cmd_t       cmd,
  input  logic                 cmd_pop
);

  zbtr_pkg::vtx_t v0, v1, v2, s0, s1, s2, t;
  zbtr_pkg::cmd_t sorted;

  zbtr_pkg::cmd_t                     q_r [zbtr_pkg::CMDQ_DEPTH];
  logic [zbtr_pkg::CMDQ_PTR_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [zbtr_pkg::CMDQ_PTR_W:0]      cnt_r, cnt_nxt;
  logic                               push_ok, pop_ok;

  // Three-step compare-exchange on y, done as the item enters.
  always_comb begin
    v0 = '{x: in_a_x, y: in_a_y, z: in_a_z};
    v1 = '{x: in_b_x, y: in_b_y, z: in_b_z};
    v2 = '{x: in_c_x, y: in_c_y, z: in_c_z};
    s0 = v0; s1 = v1; s2 = v2;
    t  = v0;
    if ($signed(s0.y) > $signed(s1.y)) begin
      t = s0; s0 = s1; s1 = t;
    end
    if ($signed(s0.y) > $signed(s2.y)) begin
      t = s0; s0 = s2; s2 = t;
    end
    if ($signed(s1.y) > $signed(s2.y)) begin
      t = s1; s1 = s2; s2 = t;
    end
    sorted.func   = in_func;
    sorted.top    = s0;
    sorted.mid    = s1;
    sorted.bot    = s2;
    sorted.colour = in_colour;
  end

  assign in_full   = (cnt_r == (zbtr_pkg::CMDQ_PTR_W+1)'(zbtr_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    wr_nxt  = push_ok ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop_ok  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= sorted;
    end
  end

endmodule

FILE: rtl/zbtr_div.sv
module zbtr_div #(
  parameter int NUM_W = zbtr_pkg::FRAC_BITS_DEF + zbtr_pkg::INT_W,
  parameter int DEN_W = zbtr_pkg::DEN_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    busy,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, dmag_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dmag_r});
  assign busy  = busy_r;
  assign done  = done_r;
  assign quo   = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= CNT_W'(NUM_W);
      rem_r  <= '0;
      q_r    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_r <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= fits ? DEN_W'(trial - {1'b0, dmag_r}) : DEN_W'(trial);
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/zbtr_back.sv
module zbtr_back #(
  parameter int FRAC_BITS     = zbtr_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH  = zbtr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = zbtr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           depth_test_enable,
  input  logic           cmd_valid,
  input  zbtr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output zbtr_pkg::res_t res,
  input  logic           res_pop
);

  localparam int ACC_W  = FRAC_BITS + zbtr_pkg::INT_W;
  localparam int DEN_W  = zbtr_pkg::DEN_W;
  localparam int IW     = zbtr_pkg::INT_W;
  localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int LINE_W = $clog2(SCREEN_HEIGHT);

  zbtr_pkg::state_t state_r, state_nxt;
  zbtr_pkg::phase_t phase_r, phase_nxt;

  zbtr_pkg::vtx_t top_r, top_nxt, mid_r, mid_nxt, bot_r, bot_nxt;
  logic [7:0]              colour_r, colour_nxt;
  logic signed [ACC_W-1:0] slope_r [4];
  logic signed [ACC_W-1:0] slope_nxt [4];
  logic signed [ACC_W-1:0] lex_r, lex_nxt, rex_r, rex_nxt;
  logic signed [ACC_W-1:0] lez_r, lez_nxt, rez_r, rez_nxt;
  logic signed [ACC_W-1:0] sdepth_r, sdepth_nxt, sstep_r, sstep_nxt;
  logic                    exch_r, exch_nxt, reslope_r, reslope_nxt;
  logic signed [12:0]      line_r, line_nxt;
  logic [COL_W-1:0]        col_r, col_nxt, send_r, send_nxt;
  logic [1:0]              k_r, k_nxt;
  logic [ADDR_W-1:0]       clr_r, clr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  zbtr_pkg::res_t          out_res_r, out_res_nxt;
  logic [7:0]              rd_q_r;

  logic [7:0] zmem [PIXELS];

  logic                    div_start, div_busy, div_done;
  logic signed [ACC_W-1:0] div_num, div_quo;
  logic signed [DEN_W-1:0] div_den;
  logic                    emit;

  logic signed [DEN_W-1:0] d02, d10, d12;
  logic signed [IW-1:0]    ax, az, bx, bz, lx_raw, rx_raw, lz, rz, lx_c, rx_c;
  logic                    span_empty, last_line, reslope_now, mem_we_px, depth_pass;
  logic signed [7:0]       pix_depth;
  logic [ADDR_W-1:0]       pix_addr;

  assign d02 = DEN_W'($signed(top_r.y)) - DEN_W'($signed(bot_r.y));
  assign d10 = DEN_W'($signed(mid_r.y)) - DEN_W'($signed(top_r.y));
  assign d12 = DEN_W'($signed(mid_r.y)) - DEN_W'($signed(bot_r.y));

  // Edge values rounded toward minus infinity are the integer slices.
  assign ax = $signed(lex_r[ACC_W-1:FRAC_BITS]);
  assign az = $signed(lez_r[ACC_W-1:FRAC_BITS]);
  assign bx = $signed(rex_r[ACC_W-1:FRAC_BITS]);
  assign bz = $signed(rez_r[ACC_W-1:FRAC_BITS]);
  assign lx_raw = exch_r ? bx : ax;
  assign rx_raw = exch_r ? ax : bx;
  assign lz     = exch_r ? bz : az;
  assign rz     = exch_r ? az : bz;
  assign lx_c   = (lx_raw < 0) ? '0 : lx_raw;
  assign rx_c   = (rx_raw > IW'(SCREEN_WIDTH - 1)) ? IW'(SCREEN_WIDTH - 1) : rx_raw;
  assign span_empty = (line_r < 0) || (line_r >= 13'(SCREEN_HEIGHT)) || (lx_c > rx_c);
  assign last_line  = (line_r >= 13'($signed(bot_r.y)));
  assign reslope_now = (line_r == 13'($signed(mid_r.y)) + 13'sd1);

  assign pix_addr  = ADDR_W'(line_r[LINE_W-1:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_r);
  assign pix_depth = $signed(sdepth_r[FRAC_BITS+7:FRAC_BITS]);
  assign depth_pass = (pix_depth > $signed(rd_q_r));
  assign mem_we_px  = (state_r == zbtr_pkg::S_PX_WR) && depth_test_enable && depth_pass;

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  // Divider operand selection: triangle setup, mid-vertex reslope, span step.
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_r)
      zbtr_pkg::S_LD_DIV, zbtr_pkg::S_LD_WAIT: begin
        case (k_r)
          2'd0: begin
            div_num = ACC_W'($signed(top_r.x) - $signed(bot_r.x)) <<< FRAC_BITS;
            div_den = d02;
          end
          2'd1: begin
            div_num = ACC_W'($signed(mid_r.x) - $signed(top_r.x)) <<< FRAC_BITS;
            div_den = d10;
          end
          2'd2: begin
            div_num = ACC_W'($signed(top_r.z) - $signed(bot_r.z)) <<< FRAC_BITS;
            div_den = d02;
          end
          default: begin
            div_num = ACC_W'($signed(mid_r.z) - $signed(top_r.z)) <<< FRAC_BITS;
            div_den = d10;
          end
        endcase
      end
      zbtr_pkg::S_LN_DIV, zbtr_pkg::S_LN_WAIT: begin
        if (k_r == 2'd0) begin
          div_num = ACC_W'($signed(mid_r.x) - $signed(bot_r.x)) <<< FRAC_BITS;
        end else begin
          div_num = ACC_W'($signed(mid_r.z) - $signed(bot_r.z)) <<< FRAC_BITS;
        end
        div_den = d12;
      end
      default: begin
        div_num = (ACC_W'(rz) - ACC_W'(lz)) <<< FRAC_BITS;
        div_den = DEN_W'(rx_c - lx_c);
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zbtr_pkg::S_CLEAR: begin
        if (clr_r == ADDR_W'(PIXELS - 1)) state_nxt = zbtr_pkg::S_WAIT;
      end
      zbtr_pkg::S_WAIT: begin
        if (cmd_valid) begin
          if (cmd.func == zbtr_pkg::FUNC_LOAD) begin
            state_nxt = zbtr_pkg::S_LD_DIV;
          end else if (!out_valid_r) begin
            case (phase_r)
              zbtr_pkg::PH_LINE: begin
                state_nxt = (reslope_now && d12 != '0) ? zbtr_pkg::S_LN_DIV
                                                       : zbtr_pkg::S_LN_STEP;
              end
              zbtr_pkg::PH_SPAN: state_nxt = zbtr_pkg::S_PX_RD;
              default:           state_nxt = zbtr_pkg::S_WAIT;
            endcase
          end
        end
      end
      zbtr_pkg::S_LD_DIV: state_nxt = zbtr_pkg::S_LD_WAIT;
      zbtr_pkg::S_LD_WAIT: begin
        if (div_done) state_nxt = (k_r == 2'd3) ? zbtr_pkg::S_LD_FIN : zbtr_pkg::S_LD_DIV;
      end
      zbtr_pkg::S_LD_FIN: state_nxt = zbtr_pkg::S_WAIT;
      zbtr_pkg::S_LN_DIV: state_nxt = zbtr_pkg::S_LN_WAIT;
      zbtr_pkg::S_LN_WAIT: begin
        if (div_done) state_nxt = (k_r == 2'd1) ? zbtr_pkg::S_LN_STEP : zbtr_pkg::S_LN_DIV;
      end
      zbtr_pkg::S_LN_STEP: state_nxt = zbtr_pkg::S_LN_EVAL;
      zbtr_pkg::S_LN_EVAL: begin
        state_nxt = span_empty ? zbtr_pkg::S_WAIT : zbtr_pkg::S_SP_WAIT;
      end
      zbtr_pkg::S_SP_WAIT: begin
        if (div_done) state_nxt = zbtr_pkg::S_PX_RD;
      end
      zbtr_pkg::S_PX_RD: state_nxt = zbtr_pkg::S_PX_WR;
      zbtr_pkg::S_PX_WR: state_nxt = zbtr_pkg::S_WAIT;
      default:           state_nxt = zbtr_pkg::S_WAIT;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_nxt   = phase_r;
    top_nxt     = top_r;
    mid_nxt     = mid_r;
    bot_nxt     = bot_r;
    colour_nxt  = colour_r;
    slope_nxt   = slope_r;
    lex_nxt     = lex_r;
    rex_nxt     = rex_r;
    lez_nxt     = lez_r;
    rez_nxt     = rez_r;
    sdepth_nxt  = sdepth_r;
    sstep_nxt   = sstep_r;
    exch_nxt    = exch_r;
    reslope_nxt = reslope_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    send_nxt    = send_r;
    k_nxt       = k_r;
    clr_nxt     = clr_r;
    cmd_pop     = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;
    out_res_nxt = out_res_r;

    case (state_r)
      zbtr_pkg::S_CLEAR: clr_nxt = clr_r + 1'b1;
      zbtr_pkg::S_WAIT: begin
        if (cmd_valid) begin
          if (cmd.func == zbtr_pkg::FUNC_LOAD) begin
            cmd_pop    = 1'b1;
            top_nxt    = cmd.top;
            mid_nxt    = cmd.mid;
            bot_nxt    = cmd.bot;
            colour_nxt = cmd.colour;
            k_nxt      = 2'd0;
          end else if (!out_valid_r) begin
            cmd_pop     = 1'b1;
            k_nxt       = 2'd0;
            reslope_nxt = reslope_now;
            if (phase_r != zbtr_pkg::PH_LINE && phase_r != zbtr_pkg::PH_SPAN) begin
              phase_nxt   = zbtr_pkg::PH_IDLE;
              emit        = 1'b1;
              out_res_nxt = '{write_valid: 1'b0, pixel_address: '0,
                              pixel_colour: '0, triangle_done: 1'b1};
            end
          end
        end
      end
      zbtr_pkg::S_LD_DIV, zbtr_pkg::S_LN_DIV: div_start = 1'b1;
      zbtr_pkg::S_LD_WAIT: begin
        if (div_done) begin
          slope_nxt[k_r] = (div_den == '0) ? '0 : div_quo;
          k_nxt          = k_r + 2'd1;
        end
      end
      zbtr_pkg::S_LD_FIN: begin
        lex_nxt   = ACC_W'($signed(top_r.x)) <<< FRAC_BITS;
        rex_nxt   = ACC_W'($signed(top_r.x)) <<< FRAC_BITS;
        lez_nxt   = ACC_W'($signed(top_r.z)) <<< FRAC_BITS;
        rez_nxt   = ACC_W'($signed(top_r.z)) <<< FRAC_BITS;
        exch_nxt  = !(slope_r[0] < slope_r[1]);
        line_nxt  = 13'($signed(top_r.y)) + 13'sd1;
        col_nxt   = '0;
        phase_nxt = (d02 == '0) ? zbtr_pkg::PH_IDLE : zbtr_pkg::PH_LINE;
      end
      zbtr_pkg::S_LN_WAIT: begin
        if (div_done) begin
          if (k_r == 2'd0) slope_nxt[1] = div_quo;
          else             slope_nxt[3] = div_quo;
          k_nxt = k_r + 2'd1;
        end
      end
      zbtr_pkg::S_LN_STEP: begin
        // Past the middle vertex the short edge restarts from it.
        lex_nxt = lex_r + slope_r[0];
        lez_nxt = lez_r + slope_r[2];
        if (reslope_r) begin
          rex_nxt  = (ACC_W'($signed(mid_r.x)) <<< FRAC_BITS) + slope_r[1];
          rez_nxt  = (ACC_W'($signed(mid_r.z)) <<< FRAC_BITS) + slope_r[3];
          exch_nxt = !(slope_r[1] < slope_r[0]);
        end else begin
          rex_nxt = rex_r + slope_r[1];
          rez_nxt = rez_r + slope_r[3];
        end
      end
      zbtr_pkg::S_LN_EVAL: begin
        if (span_empty) begin
          emit        = 1'b1;
          line_nxt    = line_r + 13'sd1;
          phase_nxt   = last_line ? zbtr_pkg::PH_IDLE : zbtr_pkg::PH_LINE;
          out_res_nxt = '{write_valid: 1'b0, pixel_address: '0,
                          pixel_colour: '0, triangle_done: last_line};
        end else begin
          div_start = 1'b1;
        end
      end
      zbtr_pkg::S_SP_WAIT: begin
        if (div_done) begin
          sstep_nxt  = (rx_c == lx_c) ? '0 : div_quo;
          sdepth_nxt = ACC_W'(lz) <<< FRAC_BITS;
          col_nxt    = COL_W'(lx_c);
          send_nxt   = COL_W'(rx_c);
          phase_nxt  = zbtr_pkg::PH_SPAN;
        end
      end
      zbtr_pkg::S_PX_WR: begin
        emit        = 1'b1;
        out_res_nxt.write_valid   = !depth_test_enable || depth_pass;
        out_res_nxt.pixel_address = out_res_nxt.write_valid ? 16'(pix_addr) : '0;
        out_res_nxt.pixel_colour  = out_res_nxt.write_valid ? colour_r : '0;
        out_res_nxt.triangle_done = 1'b0;
        sdepth_nxt = sdepth_r + sstep_r;
        col_nxt    = col_r + 1'b1;
        if (col_r >= send_r) begin
          line_nxt  = line_r + 13'sd1;
          phase_nxt = last_line ? zbtr_pkg::PH_IDLE : zbtr_pkg::PH_LINE;
          out_res_nxt.triangle_done = last_line;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (res_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zbtr_pkg::S_CLEAR;
      phase_r     <= zbtr_pkg::PH_IDLE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    mid_r     <= mid_nxt;
    bot_r     <= bot_nxt;
    colour_r  <= colour_nxt;
    slope_r   <= slope_nxt;
    lex_r     <= lex_nxt;
    rex_r     <= rex_nxt;
    lez_r     <= lez_nxt;
    rez_r     <= rez_nxt;
    sdepth_r  <= sdepth_nxt;
    sstep_r   <= sstep_nxt;
    exch_r    <= exch_nxt;
    reslope_r <= reslope_nxt;
    line_r    <= line_nxt;
    col_r     <= col_nxt;
    send_r    <= send_nxt;
    k_r       <= k_nxt;
    out_res_r <= out_res_nxt;
  end

  // Depth store: clearing pass after reset, then one read and one
  // conditional write per candidate pixel.
  always_ff @(posedge clk) begin
    if (state_r == zbtr_pkg::S_CLEAR) begin
      zmem[clr_r] <= zbtr_pkg::DEPTH_FAR;
    end else if (mem_we_px) begin
      zmem[pix_addr] <= pix_depth;
    end
    rd_q_r <= zmem[pix_addr];
  end

  zbtr_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || res_pop))
    else $error("result produced while the output slot is occupied");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_span_line: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == zbtr_pkg::PH_SPAN) |-> (line_r >= 0 && line_r < 13'(SCREEN_HEIGHT)))
    else $error("span active on a line outside the screen");

  a_span_col: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == zbtr_pkg::PH_SPAN) |-> (col_r <= send_r))
    else $error("span column past its end");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FB_W = 320;
  localparam int FB_H = 200;
  localparam int FB_PIXELS = FB_W * FB_H;
  localparam int FIX = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  // A load with no tick behind it still keeps the divider busy after the last result.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 300;

  // One input transaction as the sender sees it. The expected result is typed in
  // only for rows whose outcome is obvious; all others use the predicted result.
  typedef struct {
    logic              func;
    logic signed [11:0] ax, ay, bx, by, cx, cy;
    logic signed [7:0]  az, bz, cz;
    logic [7:0]         colour;
    bit                 typed;
    zbtr_pkg::res_t     typed_res;
  } tri_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_func = zbtr_pkg::FUNC_TICK;
  logic signed [11:0] in_a_x = '0, in_a_y = '0, in_b_x = '0, in_b_y = '0;
  logic signed [11:0] in_c_x = '0, in_c_y = '0;
  logic signed [7:0]  in_a_z = '0, in_b_z = '0, in_c_z = '0;
  logic [7:0]         in_colour = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_write_valid;
  logic [15:0] out_pixel_address;
  logic [7:0]  out_pixel_colour;
  logic out_triangle_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_depth_test_enable = 1'b0;

  always #5 clk = ~clk;

  zbuffer_triangle_rasterizer_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_func              (in_func),
    .in_a_x               (in_a_x),
    .in_a_y               (in_a_y),
    .in_a_z               (in_a_z),
    .in_b_x               (in_b_x),
    .in_b_y               (in_b_y),
    .in_b_z               (in_b_z),
    .in_c_x               (in_c_x),
    .in_c_y               (in_c_y),
    .in_c_z               (in_c_z),
    .in_colour            (in_colour),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_write_valid      (out_write_valid),
    .out_pixel_address    (out_pixel_address),
    .out_pixel_colour     (out_pixel_colour),
    .out_triangle_done    (out_triangle_done),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_depth_test_enable(cfg_depth_test_enable)
  );

  // ---------------------------------------------------------------------------
  // Rasterizer model state. This mirrors what the block keeps between
  // transactions: the depth store, the edge accumulators and slopes, the two
  // vertices still ahead after sorting, and the scan position.
  // ---------------------------------------------------------------------------
  byte       depth_mem [FB_PIXELS];
  bit        zt_enable;
  longint    edge_lx, edge_rx, edge_lz, edge_rz;
  longint    slope [4]; // long dx, short dx, long dz, short dz
  int        mid_x, mid_y, mid_z, bot_x, bot_y, bot_z;
  int        scan_line, scan_col, span_last;
  longint    span_z, span_dz;
  zbtr_pkg::phase_t raster_ph;
  bit        edges_swapped;
  logic [7:0] tri_col;

  zbtr_pkg::res_t pending_pixels [$];
  int     n_fail = 0;
  longint n_cycles = 0;
  bit     quiet = 1'b0;    // no idling near the end of the run
  bit     hold_req = 1'b0; // asks the receiver for one long stall

  function automatic longint to_fix(longint v);
    return v * (longint'(1) << FIX);
  endfunction

  function automatic void model_reset();
    foreach (depth_mem[i]) depth_mem[i] = -128;
    zt_enable = 1'b1;
    edge_lx = 0; edge_rx = 0; edge_lz = 0; edge_rz = 0;
    foreach (slope[i]) slope[i] = 0;
    mid_x = 0; mid_y = 0; mid_z = 0; bot_x = 0; bot_y = 0; bot_z = 0;
    scan_line = 0; scan_col = 0; span_last = 0;
    span_z = 0; span_dz = 0;
    raster_ph = zbtr_pkg::PH_IDLE;
    edges_swapped = 1'b0;
    tri_col = '0;
  endfunction

  // Leaving a scanline: the bottom line of the triangle ends it.
  function automatic void close_line(ref zbtr_pkg::res_t r);
    bit last;
    last = scan_line >= bot_y;
    scan_line++;
    raster_ph = last ? zbtr_pkg::PH_IDLE : zbtr_pkg::PH_LINE;
    r.triangle_done = last;
  endfunction

  // Returns 1 when the transaction yields a result.
  function automatic bit raster_predict(input tri_item_t it, output zbtr_pkg::res_t r);
    longint x [3], y [3], z [3], t;
    longint ax, az, bx, bz, lx, lz, rx, rz, dy;
    int col, addr;
    byte dep;
    bit wr;
    r = '0;
    if (it.func == zbtr_pkg::FUNC_LOAD) begin
      x[0] = it.ax; y[0] = it.ay; z[0] = it.az;
      x[1] = it.bx; y[1] = it.by; z[1] = it.bz;
      x[2] = it.cx; y[2] = it.cy; z[2] = it.cz;
      // Three-step sort by y.
      for (int p = 0; p < 2; p++) begin
        for (int q = p + 1; q < 3; q++) begin
          if (y[p] > y[q]) begin
            t = x[p]; x[p] = x[q]; x[q] = t;
            t = y[p]; y[p] = y[q]; y[q] = t;
            t = z[p]; z[p] = z[q]; z[q] = t;
          end
        end
      end
      foreach (slope[i]) slope[i] = 0;
      if (y[0] != y[2]) begin
        slope[0] = to_fix(x[0] - x[2]) / (y[0] - y[2]);
        slope[2] = to_fix(z[0] - z[2]) / (y[0] - y[2]);
      end
      if (y[0] != y[1]) begin
        slope[1] = to_fix(x[1] - x[0]) / (y[1] - y[0]);
        slope[3] = to_fix(z[1] - z[0]) / (y[1] - y[0]);
      end
      edge_lx = to_fix(x[0]); edge_rx = edge_lx;
      edge_lz = to_fix(z[0]); edge_rz = edge_lz;
      edges_swapped = !(slope[0] < slope[1]);
      mid_x = int'(x[1]); mid_y = int'(y[1]); mid_z = int'(z[1]);
      bot_x = int'(x[2]); bot_y = int'(y[2]); bot_z = int'(z[2]);
      scan_line = int'(y[0]) + 1;
      scan_col = 0;
      raster_ph = (y[0] == y[2]) ? zbtr_pkg::PH_IDLE : zbtr_pkg::PH_LINE;
      tri_col = it.colour;
      return 1'b0;
    end

    if (raster_ph != zbtr_pkg::PH_LINE && raster_ph != zbtr_pkg::PH_SPAN) begin
      raster_ph = zbtr_pkg::PH_IDLE;
      r.triangle_done = 1'b1;
      return 1'b1;
    end

    if (raster_ph == zbtr_pkg::PH_LINE) begin
      // Just past the middle vertex the short edge turns onto the lower side.
      if (scan_line == mid_y + 1) begin
        dy = longint'(mid_y) - bot_y;
        if (dy != 0) begin
          slope[1] = to_fix(longint'(mid_x) - bot_x) / dy;
          slope[3] = to_fix(longint'(mid_z) - bot_z) / dy;
        end
        edge_rx = to_fix(mid_x);
        edge_rz = to_fix(mid_z);
        edges_swapped = !(slope[1] < slope[0]);
      end
      edge_lx += slope[0];
      edge_rx += slope[1];
      edge_lz += slope[2];
      edge_rz += slope[3];
      ax = edge_lx >>> FIX; az = edge_lz >>> FIX;
      bx = edge_rx >>> FIX; bz = edge_rz >>> FIX;
      if (edges_swapped) begin
        lx = bx; lz = bz; rx = ax; rz = az;
      end else begin
        lx = ax; lz = az; rx = bx; rz = bz;
      end
      if (lx < 0) lx = 0;
      if (rx > FB_W - 1) rx = FB_W - 1;
      if (scan_line < 0 || scan_line >= FB_H || lx > rx) begin
        close_line(r);
        return 1'b1;
      end
      span_dz = (rx == lx) ? 0 : to_fix(rz - lz) / (rx - lx);
      span_z = to_fix(lz);
      scan_col = int'(lx);
      span_last = int'(rx);
      raster_ph = zbtr_pkg::PH_SPAN;
    end

    // One candidate pixel; z is not corrected for the clipped span start.
    col = scan_col;
    dep = byte'(span_z >>> FIX);
    addr = scan_line * FB_W + col;
    wr = 1'b1;
    if (addr < 0 || addr >= FB_PIXELS) begin
      wr = 1'b0;
    end else if (zt_enable) begin
      if (dep > depth_mem[addr]) depth_mem[addr] = dep;
      else wr = 1'b0;
    end
    if (wr) begin
      r.write_valid = 1'b1;
      r.pixel_address = addr[15:0];
      r.pixel_colour = tri_col;
    end
    span_z += span_dz;
    scan_col = col + 1;
    if (col >= span_last) close_line(r);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  task automatic send_item(input tri_item_t it);
    zbtr_pkg::res_t r;
    in_func <= it.func;
    in_a_x <= it.ax; in_a_y <= it.ay; in_a_z <= it.az;
    in_b_x <= it.bx; in_b_y <= it.by; in_b_z <= it.bz;
    in_c_x <= it.cx; in_c_y <= it.cy; in_c_z <= it.cz;
    in_colour <= it.colour;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    if (raster_predict(it, r)) pending_pixels.push_back(it.typed ? it.typed_res : r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // The register is only touched with nothing in flight.
  task automatic write_zt_enable(input bit v);
    in_push <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_depth_test_enable <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    zt_enable = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic tri_item_t tick_item();
    tri_item_t it;
    it = '{default: '0};
    it.func = zbtr_pkg::FUNC_TICK;
    // Fields of a tick are don't-care; random content toggles the bits anyway.
    it.ax = 12'($urandom); it.ay = 12'($urandom); it.az = 8'($urandom);
    it.colour = 8'($urandom);
    return it;
  endfunction

  function automatic tri_item_t load_item(input bit wide);
    tri_item_t it;
    it = '{default: '0};
    it.func = zbtr_pkg::FUNC_LOAD;
    if (wide) begin
      it.ax = 12'($urandom); it.ay = 12'($urandom); it.bx = 12'($urandom);
      it.by = 12'($urandom); it.cx = 12'($urandom); it.cy = 12'($urandom);
    end else begin
      // Small triangles near the screen, some crossing its edges.
      it.ax = 12'(int'($urandom_range(0, 360)) - 20);
      it.ay = 12'(int'($urandom_range(0, 240)) - 20);
      it.bx = 12'(int'(it.ax) + int'($urandom_range(0, 40)) - 20);
      it.by = 12'(int'(it.ay) + int'($urandom_range(0, 24)) - 12);
      it.cx = 12'(int'(it.ax) + int'($urandom_range(0, 40)) - 20);
      it.cy = 12'(int'(it.ay) + int'($urandom_range(0, 24)) - 12);
    end
    it.az = 8'($urandom); it.bz = 8'($urandom); it.cz = 8'($urandom);
    it.colour = 8'($urandom);
    return it;
  endfunction

  // Well-formed sequences: a load followed by a run of ticks, with occasional
  // stray ticks and loads that get abandoned early.
  task automatic random_phase(input int n_items, input bit with_hold);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      if (with_hold && sent > n_items / 2 && !hold_req) hold_req = 1'b1;
      send_item(load_item($urandom_range(0, 9) == 0));
      sent++;
      run = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(3, 40);
      repeat (run) begin
        send_item(tick_item());
        sent++;
      end
    end
  endtask

  // Directed rows: idle results are typed in, the rest are predicted.
  function automatic tri_item_t row(input logic f, input int ax, ay, az, bx, by, bz,
                                    input int cx, cy, cz, col, input bit typed);
    tri_item_t it;
    it = '{default: '0};
    it.func = f;
    it.ax = 12'(ax); it.ay = 12'(ay); it.az = 8'(az);
    it.bx = 12'(bx); it.by = 12'(by); it.bz = 8'(bz);
    it.cx = 12'(cx); it.cy = 12'(cy); it.cz = 8'(cz);
    it.colour = 8'(col);
    it.typed = typed;
    if (typed) it.typed_res = '{write_valid: 1'b0, pixel_address: '0,
                                pixel_colour: '0, triangle_done: 1'b1};
    return it;
  endfunction

  tri_item_t directed [$];

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Idle after reset, a flat triangle that goes straight to idle, a small
    // triangle with a middle-vertex turn, one with coordinates at the field
    // extremes, one above the screen, and one clipped at the right border.
    directed.push_back(row(zbtr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(row(zbtr_pkg::FUNC_LOAD, 5, 50, 3, 90, 50, 4, 40, 50, 5, 7, 0));
    directed.push_back(row(zbtr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(row(zbtr_pkg::FUNC_LOAD, 10, 10, 100, 14, 13, -20, 6, 15, 50, 33,
                           0));
    repeat (8) directed.push_back(row(zbtr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                      0));
    directed.push_back(row(zbtr_pkg::FUNC_LOAD, -2048, -2048, -128, 2047, 2047, 127,
                           -2048, 2047, 127, 255, 0));
    repeat (3) directed.push_back(row(zbtr_pkg::FUNC_TICK, -1, -1, -1, -1, -1, -1, -1, -1,
                                      -1, 255, 0));
    directed.push_back(row(zbtr_pkg::FUNC_LOAD, 100, -30, 0, 120, -10, 0, 80, -5, 0, 1, 0));
    repeat (3) directed.push_back(row(zbtr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                      0));
    directed.push_back(row(zbtr_pkg::FUNC_LOAD, 316, 100, 127, 330, 102, 127, 310, 104,
                           127, 128, 0));
    repeat (5) directed.push_back(row(zbtr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                      0));

    write_zt_enable(1'b1);
    foreach (directed[i]) send_item(directed[i]);

    // Phases alternate the fill mode, ending with depth testing on again.
    write_zt_enable(1'b0);
    random_phase(250, 1'b1);
    write_zt_enable(1'b1);
    random_phase(300, 1'b0);
    write_zt_enable(1'b0);
    random_phase(250, 1'b0);
    write_zt_enable(1'b1);
    quiet = 1'b1;
    random_phase(300, 1'b0);
    in_push <= 1'b0;

    wait (pending_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("[zbuffer_triangle_rasterizer_core] OK");
    else $display("[zbuffer_triangle_rasterizer_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: checks each popped transaction, stalls at random, and
  // honors one long hold-off so the input queue fills up.
  // ---------------------------------------------------------------------------
  initial begin
    zbtr_pkg::res_t exp_r;
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected result: no transaction pending");
          n_fail++;
        end else begin
          exp_r = pending_pixels.pop_front();
          if (out_write_valid !== exp_r.write_valid) begin
            $error("write_valid: expected %0d, got %0d", exp_r.write_valid, out_write_valid);
            n_fail++;
          end
          if (out_pixel_address !== exp_r.pixel_address) begin
            $error("pixel_address: expected %0d, got %0d", exp_r.pixel_address,
                   out_pixel_address);
            n_fail++;
          end
          if (out_pixel_colour !== exp_r.pixel_colour) begin
            $error("pixel_colour: expected %0d, got %0d", exp_r.pixel_colour,
                   out_pixel_colour);
            n_fail++;
          end
          if (out_triangle_done !== exp_r.triangle_done) begin
            $error("triangle_done: expected %0d, got %0d", exp_r.triangle_done,
                   out_triangle_done);
            n_fail++;
          end
        end
      end
      if (hold_req && !held) begin
        // Long hold-off, counted here; it happens exactly once.
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
        stall = 0;
        out_pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        if (stall == 0) out_pop <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        stall = $urandom_range(1, 4);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: covers the depth-store sweep after reset plus every division.
  initial begin
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("[zbuffer_triangle_rasterizer_core] ERROR");
        $finish;
      end
    end
  end

endmodule
